FILE: hdl/frs_pkg.sv
// ----------------------------------------------------------------------------
// frs_pkg
// Shared command codes and pixel constants for the frame rotate/flip/shift
// block.
// ----------------------------------------------------------------------------
package frs_pkg;

    typedef enum logic [2:0] {
        CMD_WRITE  = 3'd0,
        CMD_READ   = 3'd1,
        CMD_SHIFTR = 3'd2,
        CMD_SHIFTU = 3'd3,
        CMD_ROTATE = 3'd4,
        CMD_FLIPR  = 3'd5,
        CMD_FLIPC  = 3'd6,
        CMD_NONE   = 3'd7
    } t_cmd;

    localparam logic [23:0] WHITE     = 24'hFFFFFF;
    localparam int          SIDE_W    = 7;
    localparam logic [6:0]  SIDE_RST  = 7'd64;

endpackage

FILE: hdl/frame_rotate_flip_shift.sv
// ----------------------------------------------------------------------------
// frame_rotate_flip_shift
// Square frame store of 24-bit pixels with pixel access and in-place
// shift, rotate and flip transforms.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// command   in         start & !busy           command,row,column,pixel_in,amount
// result    out        o_valid, one cycle      o_pixel_out, o_coord_error
// config    in         i_cfg_we                i_cfg_data (frame side)
//
// Pixel write: result in the cycle after the transfer, next command straight on.
// Pixel read: the pixel passes the frame memory read register, then S_READ.
// Transforms: a copy of the n-by-n frame to scratch memory, one pixel a cycle,
// then the move back. Rotation by zero or command 7: result in the cycle after.
// After reset a clearing pass writes white to all MAX_SIDE*MAX_SIDE pixels,
// one a cycle, with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module frame_rotate_flip_shift #(
    parameter int MAX_SIDE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_column,
    input  logic [23:0] i_pixel_in,
    input  logic signed [7:0] i_amount,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    output logic        o_valid,
    output logic [23:0] o_pixel_out,
    output logic        o_coord_error
);

    localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int ADW   = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int SXW   = ((SW > 8) ? SW : 8) + 2;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_COPY, S_GAP, S_MOVE, S_DRAIN
    } t_state;

    t_state              r_state;
    logic [6:0]          r_side;
    logic [ADW-1:0]      r_clr;
    logic [CW-1:0]       r_r, r_c;
    frs_pkg::t_cmd       r_op;
    logic signed [7:0]   r_amt;
    logic                r_pv, r_pmove, r_pwhite;
    logic [ADW-1:0]      r_pdst;

    logic [23:0]         frame_mem [DEPTH];
    logic [23:0]         scr_mem   [DEPTH];
    logic [23:0]         r_frame_q, r_scr_q;

    logic [SW-1:0]       side_n;
    logic                in_frame, scan_last, src_ok;
    logic [ADW-1:0]      cur_addr, src_addr, pix_addr;
    logic signed [SXW-1:0] sr, sc, nm1, rs, cs, amt_x;
    logic                fr_we;
    logic [ADW-1:0]      fr_wa, fr_ra;
    logic [23:0]         fr_wd;

    function automatic logic [ADW-1:0] addr_of(input logic [CW-1:0] r,
                                               input logic [CW-1:0] c);
        addr_of = ADW'(ADW'(r) * ADW'(MAX_SIDE) + ADW'(c));
    endfunction

    // side in use, clamped to 1..MAX_SIDE
    always_comb begin
        if (r_side == 7'd0)
            side_n = SW'(1);
        else if (32'(r_side) > MAX_SIDE)
            side_n = SW'(MAX_SIDE);
        else
            side_n = SW'(r_side);
    end

    assign busy      = (r_state != S_IDLE);
    assign in_frame  = (32'(i_row) < 32'(side_n)) && (32'(i_column) < 32'(side_n));
    assign pix_addr  = ADW'(ADW'(i_row) * ADW'(MAX_SIDE) + ADW'(i_column));
    assign scan_last = (32'(r_r) == 32'(side_n) - 1) && (32'(r_c) == 32'(side_n) - 1);
    assign cur_addr  = addr_of(r_r, r_c);

    // source pixel of the move phase
    always_comb begin
        nm1   = $signed(SXW'(side_n)) - SXW'(1);
        rs    = $signed(SXW'(r_r));
        cs    = $signed(SXW'(r_c));
        amt_x = SXW'(r_amt);
        sr    = rs;
        sc    = cs;
        case (r_op)
            frs_pkg::CMD_SHIFTR: sc = cs - amt_x;
            frs_pkg::CMD_SHIFTU: sr = rs + amt_x;
            frs_pkg::CMD_FLIPR:  sr = nm1 - rs;
            frs_pkg::CMD_FLIPC:  sc = nm1 - cs;
            frs_pkg::CMD_ROTATE: begin
                case (r_amt[1:0])
                    2'd1:    begin sr = nm1 - cs; sc = rs;       end
                    2'd2:    begin sr = nm1 - rs; sc = nm1 - cs; end
                    2'd3:    begin sr = cs;       sc = nm1 - rs; end
                    default: begin sr = rs;       sc = cs;       end
                endcase
            end
            default: ;
        endcase
        src_ok   = (sr >= 0) && (sr <= nm1) && (sc >= 0) && (sc <= nm1);
        src_addr = addr_of(CW'(sr), CW'(sc));
    end

    // frame memory port selection
    always_comb begin
        fr_we = 1'b0;
        fr_wa = r_pdst;
        fr_wd = r_pwhite ? frs_pkg::WHITE : r_scr_q;
        fr_ra = cur_addr;
        if (r_state == S_CLEAR) begin
            fr_we = 1'b1;
            fr_wa = r_clr;
            fr_wd = frs_pkg::WHITE;
        end else if (r_state == S_IDLE) begin
            fr_ra = pix_addr;
            if (start && i_command == frs_pkg::CMD_WRITE && in_frame) begin
                fr_we = 1'b1;
                fr_wa = pix_addr;
                fr_wd = i_pixel_in;
            end
        end else if (r_pv && r_pmove) begin
            fr_we = 1'b1;
        end
    end

    // frame memory
    always_ff @(posedge i_clk) begin
        if (fr_we)
            frame_mem[fr_wa] <= fr_wd;
        r_frame_q <= frame_mem[fr_ra];
    end

    // scratch memory: written in the copy phase, read in the move phase
    always_ff @(posedge i_clk) begin
        if (r_pv && !r_pmove)
            scr_mem[r_pdst] <= r_frame_q;
        r_scr_q <= scr_mem[src_addr];
    end

    // sequencer, result register and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_side        <= frs_pkg::SIDE_RST;
            r_clr         <= '0;
            r_pv          <= 1'b0;
            o_valid       <= 1'b0;
            o_pixel_out   <= '0;
            o_coord_error <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            r_pv    <= 1'b0;
            if (i_cfg_we)
                r_side <= i_cfg_data;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADW'(DEPTH - 1))
                        r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start) begin
                        r_op  <= frs_pkg::t_cmd'(i_command);
                        r_amt <= i_amount;
                        r_r   <= '0;
                        r_c   <= '0;
                        o_pixel_out   <= '0;
                        o_coord_error <= 1'b0;
                        case (i_command)
                            frs_pkg::CMD_WRITE: begin
                                o_valid       <= 1'b1;
                                o_coord_error <= !in_frame;
                            end
                            frs_pkg::CMD_READ: begin
                                if (in_frame) begin
                                    r_state <= S_READ;
                                end else begin
                                    o_valid       <= 1'b1;
                                    o_coord_error <= 1'b1;
                                end
                            end
                            frs_pkg::CMD_ROTATE: begin
                                if (i_amount[1:0] == 2'd0)
                                    o_valid <= 1'b1;
                                else
                                    r_state <= S_COPY;
                            end
                            frs_pkg::CMD_NONE: o_valid <= 1'b1;
                            default: r_state <= S_COPY;
                        endcase
                    end
                end
                S_READ: begin
                    o_valid     <= 1'b1;
                    o_pixel_out <= r_frame_q;
                    r_state     <= S_IDLE;
                end
                S_COPY, S_MOVE: begin
                    r_pv     <= 1'b1;
                    r_pmove  <= (r_state == S_MOVE);
                    r_pdst   <= cur_addr;
                    r_pwhite <= (r_state == S_MOVE) && !src_ok;
                    if (scan_last) begin
                        r_r     <= '0;
                        r_c     <= '0;
                        r_state <= (r_state == S_COPY) ? S_GAP : S_DRAIN;
                    end else if (32'(r_c) == 32'(side_n) - 1) begin
                        r_c <= '0;
                        r_r <= r_r + 1'b1;
                    end else begin
                        r_c <= r_c + 1'b1;
                    end
                end
                S_GAP: r_state <= S_MOVE;
                S_DRAIN: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/frs_chk.sv
// ----------------------------------------------------------------------------
// frs_chk
// Port-level checks for frame_rotate_flip_shift, bound to the top level.
// ----------------------------------------------------------------------------
module frs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_command,
    input logic        o_valid,
    input logic [23:0] o_pixel_out,
    input logic        o_coord_error
);

    // a result only follows a transfer or work in progress
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start) && !$past(busy)) || $past(busy))
        else $error("result without a command");

    // a write transfer answers in the very next cycle
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == frs_pkg::CMD_WRITE) |=> o_valid && !busy)
        else $error("pixel write gave no result");

    // coordinate error carries no pixel
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_coord_error) |-> o_pixel_out == 24'd0)
        else $error("error result with pixel data");

    // a row flip transfer starts a whole-frame pass
    a_xform_noerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == frs_pkg::CMD_FLIPR) |=> busy)
        else $error("flip did not start");

endmodule

bind frame_rotate_flip_shift frs_chk u_frs_chk (.*);
